// ===== src/ptq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_pkg: shared types and constants of the priority transmit queues
// Action, result kind and register codes, field widths, reset values and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ptq_pkg;

  // Default geometry
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_CLASS_COUNT = 4;

  // Field widths
  localparam int ACT_W   = 2;
  localparam int CLS_W   = 2;
  localparam int TAG_W   = 16;
  localparam int RATE_W  = 4;
  localparam int KIND_W  = 2;
  localparam int TOT_W   = 32;
  localparam int RUN_W   = 8;
  localparam int FAIL_W  = 2;
  localparam int ENTRY_W = TAG_W + RATE_W;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Rate adaptation constants
  localparam logic [FAIL_W-1:0] FAIL_LIMIT     = 2'd3;
  localparam logic [RATE_W-1:0] RESET_MAX_RATE = 4'd11;
  localparam logic [RUN_W-1:0]  RESET_PROBE    = 8'd10;
  localparam logic [RUN_W-1:0]  RUN_MAX        = 8'd255;

  // Input actions
  localparam logic [ACT_W-1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FLUSH   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_OUTCOME = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FRAME  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RATE   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE    = 1'd1;

  // Controller to datapath commands
  typedef struct packed {
    logic enq;
    logic outcome;
    logic pop;
    logic empty_flush;
  } ptq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic any_queued;
    logic res_last;
  } ptq_status_t;

endpackage

// ===== src/ptq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_if: handshake channels of the priority transmit queues
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface ptq_item_if import ptq_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [CLS_W-1:0] access_class;
  logic [TAG_W-1:0] frame_tag;
  logic             success;

  modport source (output valid, action, access_class, frame_tag, success, input ready);
  modport sink (input valid, action, access_class, frame_tag, success, output ready);
endinterface

interface ptq_result_if import ptq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic              dropped;
  logic [TOT_W-1:0]  drop_total;
  logic              has_frame;
  logic [TAG_W-1:0]  out_tag;
  logic [CLS_W-1:0]  out_class;
  logic [RATE_W-1:0] out_rate;
  logic              last;
  logic [RATE_W-1:0] current_rate;
  logic [TOT_W-1:0]  fallback_total;

  modport source (output valid, kind, dropped, drop_total, has_frame, out_tag, out_class,
                  out_rate, last, current_rate, fallback_total, input ready);
  modport sink (input valid, kind, dropped, drop_total, has_frame, out_tag, out_class,
                out_rate, last, current_rate, fallback_total, output ready);
endinterface

interface ptq_cfg_if import ptq_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/priority_tx_queues_with_rate_adapt_core.sv =====
`timescale 1ns / 1ps
// Each result is registered and shown in the cycle after the transaction that causes it.
// Enqueue, transmit outcome and an empty flush give one result each; a flush
// of N queued frames gives N results at one per cycle while the sink is ready (one read
// port on the frame memory); the next item is taken in the cycle after its last frame.
// Reset (rst, synchronous): queues empty, rate and counters zero, max_rate 11 and
// probe_successes 10; the frame memory needs no clearing pass.
// ----------------------------------------------------------------------------
// priority_tx_queues_with_rate_adapt_core: strict-priority tx queues with ARF
// Per-class ring queues of frame tags drained highest class first, plus
// success/failure driven rate adaptation with drop and fallback counters.
// ----------------------------------------------------------------------------
module priority_tx_queues_with_rate_adapt_core import ptq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int CLASS_COUNT = DEF_CLASS_COUNT
) (
  input  logic         clk,
  input  logic         rst,
  ptq_item_if.sink     item,
  ptq_result_if.source result,
  ptq_cfg_if.sink      cfg
);

  ptq_cmd_t    cmd;
  ptq_status_t status;

  // Configuration writes are always taken
  assign cfg.ready = 1'b1;

  ptq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .action     (item.action),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .cmd        (cmd),
    .status     (status)
  );

  ptq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CLASS_COUNT (CLASS_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .access_class   (item.access_class),
    .frame_tag      (item.frame_tag),
    .success        (item.success),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .kind           (result.kind),
    .dropped        (result.dropped),
    .drop_total     (result.drop_total),
    .has_frame      (result.has_frame),
    .out_tag        (result.out_tag),
    .out_class      (result.out_class),
    .out_rate       (result.out_rate),
    .last           (result.last),
    .current_rate   (result.current_rate),
    .fallback_total (result.fallback_total)
  );

endmodule

// ===== src/ptq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_ram: generic single-write, single-read RAM
// One write port, one read port with read enable and registered read data.
// ----------------------------------------------------------------------------
module ptq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/ptq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_datapath: queue bookkeeping, rate adaptation and result register
// Holds heads, counts, the frame memory, rate state, counters, the
// configuration registers and the registered result fields.
// ----------------------------------------------------------------------------
module ptq_datapath import ptq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int CLASS_COUNT = DEF_CLASS_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ptq_cmd_t              cmd,
  output ptq_status_t           status,
  input  logic [CLS_W-1:0]      access_class,
  input  logic [TAG_W-1:0]      frame_tag,
  input  logic                  success,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [KIND_W-1:0]     kind,
  output logic                  dropped,
  output logic [TOT_W-1:0]      drop_total,
  output logic                  has_frame,
  output logic [TAG_W-1:0]      out_tag,
  output logic [CLS_W-1:0]      out_class,
  output logic [RATE_W-1:0]     out_rate,
  output logic                  last,
  output logic [RATE_W-1:0]     current_rate,
  output logic [TOT_W-1:0]      fallback_total
);

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int SUM_W  = IDX_W + 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int CIDX_W = $clog2(CLASS_COUNT);
  localparam int SLOTS  = CLASS_COUNT * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam logic [ADDR_W-1:0] DEPTH_A   = ADDR_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0]  DEPTH_S   = SUM_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0]  DEPTH_C   = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CLS_W:0]    CLASS_LIM = (CLS_W + 1)'(CLASS_COUNT);

  // Queue state
  logic [CNT_W-1:0] counts [CLASS_COUNT];
  logic [IDX_W-1:0] heads  [CLASS_COUNT];

  // Rate state and counters
  logic [RATE_W-1:0] rate_index;
  logic [RUN_W-1:0]  success_run;
  logic [FAIL_W-1:0] failure_run;
  logic [TOT_W-1:0]  drop_counter;
  logic [TOT_W-1:0]  fallback_counter;
  logic [RATE_W-1:0] max_rate;
  logic [RUN_W-1:0]  probe_successes;

  // Result register
  logic [KIND_W-1:0] res_kind;
  logic              res_dropped;
  logic [TOT_W-1:0]  res_total;
  logic              res_has_frame;
  logic [CLS_W-1:0]  res_class;
  logic              res_last;
  logic [RATE_W-1:0] res_rate;

  // Enqueue path
  logic              class_ok;
  logic [CIDX_W-1:0] enq_cls;
  logic              enq_full;
  logic              enq_store;
  logic [SUM_W-1:0]  slot_sum;
  logic [IDX_W-1:0]  enq_slot;
  logic [ADDR_W-1:0] wr_addr;

  // Pop path
  logic [CIDX_W-1:0] sel;
  logic              any_queued;
  logic              lower_any;
  logic              pop_last;
  logic [IDX_W-1:0]  head_adv;
  logic [ADDR_W-1:0] rd_addr;

  // Rate path
  logic [RATE_W-1:0] rate_next;
  logic [RUN_W-1:0]  success_next;
  logic [FAIL_W-1:0] failure_next;
  logic [TOT_W-1:0]  fallback_next;

  logic [ENTRY_W-1:0] rd_entry;

  // Locate the write slot of the addressed queue
  always_comb begin
    class_ok  = {1'b0, access_class} < CLASS_LIM;
    enq_cls   = access_class[CIDX_W-1:0];
    enq_full  = counts[enq_cls] >= DEPTH_C;
    enq_store = cmd.enq && class_ok && !enq_full;
    slot_sum  = SUM_W'(heads[enq_cls]) + SUM_W'(counts[enq_cls]);
    if (slot_sum >= DEPTH_S) begin
      enq_slot = IDX_W'(slot_sum - DEPTH_S);
    end else begin
      enq_slot = IDX_W'(slot_sum);
    end
    wr_addr = ADDR_W'(enq_cls) * DEPTH_A + ADDR_W'(enq_slot);
  end

  // Pick the highest non-empty class and check whether this pop ends the run
  always_comb begin
    sel        = '0;
    any_queued = 1'b0;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      if (counts[c] != '0) begin
        sel        = CIDX_W'(c);
        any_queued = 1'b1;
      end
    end
    lower_any = 1'b0;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      if ((CIDX_W'(c) < sel) && (counts[c] != '0)) begin
        lower_any = 1'b1;
      end
    end
    pop_last = (counts[sel] == CNT_W'(1)) && !lower_any;
    head_adv = (heads[sel] == LAST_SLOT) ? '0 : heads[sel] + 1'b1;
    rd_addr  = ADDR_W'(sel) * DEPTH_A + ADDR_W'(heads[sel]);
  end

  // Step the rate up on a long enough success run, down on three failures
  always_comb begin
    rate_next     = rate_index;
    success_next  = success_run;
    failure_next  = failure_run;
    fallback_next = fallback_counter;
    if (success) begin
      failure_next = '0;
      success_next = (success_run < RUN_MAX) ? success_run + 1'b1 : success_run;
      if ((success_next >= probe_successes) && (rate_index < max_rate)) begin
        rate_next    = rate_index + 1'b1;
        success_next = '0;
      end
    end else begin
      success_next = '0;
      failure_next = (failure_run < FAIL_LIMIT) ? failure_run + 1'b1 : failure_run;
      if ((failure_next >= FAIL_LIMIT) && (rate_index != '0)) begin
        rate_next     = rate_index - 1'b1;
        failure_next  = '0;
        fallback_next = fallback_counter + 1'b1;
      end
    end
  end

  // Frame memory: tag with the rate stamped at enqueue
  ptq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (enq_store),
    .waddr (wr_addr),
    .wdata ({rate_index, frame_tag}),
    .re    (cmd.pop),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  // Update queue, rate and configuration state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        counts[c] <= '0;
        heads[c]  <= '0;
      end
      rate_index       <= '0;
      success_run      <= '0;
      failure_run      <= '0;
      drop_counter     <= '0;
      fallback_counter <= '0;
      max_rate         <= RESET_MAX_RATE;
      probe_successes  <= RESET_PROBE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_RATE: max_rate        <= cfg_data[RATE_W-1:0];
          CFG_PROBE:    probe_successes <= cfg_data;
          default:      ;
        endcase
      end
      if (cmd.enq && class_ok) begin
        if (enq_full) begin
          drop_counter <= drop_counter + 1'b1;
        end else begin
          counts[enq_cls] <= counts[enq_cls] + 1'b1;
        end
      end
      if (cmd.pop) begin
        counts[sel] <= counts[sel] - 1'b1;
        heads[sel]  <= head_adv;
      end
      if (cmd.outcome) begin
        rate_index       <= rate_next;
        success_run      <= success_next;
        failure_run      <= failure_next;
        fallback_counter <= fallback_next;
      end
    end
  end

  // Load the result register; fields outside the kind stay zero
  always_ff @(posedge clk) begin
    if (rst) begin
      res_last <= 1'b0;
    end else begin
      priority if (cmd.enq) begin
        res_kind      <= KIND_STATUS;
        res_dropped   <= !(class_ok && !enq_full);
        res_total     <= (class_ok && enq_full) ? drop_counter + 1'b1 : drop_counter;
        res_has_frame <= 1'b0;
        res_class     <= '0;
        res_last      <= 1'b0;
        res_rate      <= '0;
      end else if (cmd.pop) begin
        res_kind      <= KIND_FRAME;
        res_dropped   <= 1'b0;
        res_total     <= '0;
        res_has_frame <= 1'b1;
        res_class     <= CLS_W'(sel);
        res_last      <= pop_last;
        res_rate      <= '0;
      end else if (cmd.empty_flush) begin
        res_kind      <= KIND_FRAME;
        res_dropped   <= 1'b0;
        res_total     <= '0;
        res_has_frame <= 1'b0;
        res_class     <= '0;
        res_last      <= 1'b1;
        res_rate      <= '0;
      end else if (cmd.outcome) begin
        res_kind      <= KIND_RATE;
        res_dropped   <= 1'b0;
        res_total     <= fallback_next;
        res_has_frame <= 1'b0;
        res_class     <= '0;
        res_last      <= 1'b0;
        res_rate      <= rate_next;
      end
    end
  end

  assign status.any_queued = any_queued;
  assign status.res_last   = res_last;

  // Drive result fields; frame fields come straight from the memory read
  assign kind           = res_kind;
  assign dropped        = res_dropped;
  assign drop_total     = (res_kind == KIND_STATUS) ? res_total : '0;
  assign fallback_total = (res_kind == KIND_RATE) ? res_total : '0;
  assign has_frame      = res_has_frame;
  assign out_tag        = res_has_frame ? rd_entry[TAG_W-1:0] : '0;
  assign out_rate       = res_has_frame ? rd_entry[ENTRY_W-1:TAG_W] : '0;
  assign out_class      = res_class;
  assign last           = res_last;
  assign current_rate   = res_rate;

endmodule

// ===== src/ptq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_ctrl: transaction controller of the priority transmit queues
// Accepts items, issues datapath commands and runs flush sequences one
// frame per output transaction.
// ----------------------------------------------------------------------------
module ptq_ctrl import ptq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  logic [ACT_W-1:0] action,
  output logic             out_valid,
  input  logic             out_ready,
  output ptq_cmd_t         cmd,
  input  ptq_status_t      status
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FLUSH = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   accept;

  // In idle, take a new item once the result register is free or being freed
  assign item_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept     = item_valid && item_ready;

  // Sequence commands
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_ENQUEUE: begin
              cmd.enq        = 1'b1;
              out_valid_next = 1'b1;
            end
            ACT_FLUSH: begin
              out_valid_next = 1'b1;
              if (status.any_queued) begin
                cmd.pop    = 1'b1;
                state_next = S_FLUSH;
              end else begin
                cmd.empty_flush = 1'b1;
              end
            end
            ACT_OUTCOME: begin
              cmd.outcome    = 1'b1;
              out_valid_next = 1'b1;
            end
            default: out_valid_next = 1'b0;
          endcase
        end
      end
      S_FLUSH: begin
        out_valid_next = 1'b1;
        if (out_ready) begin
          if (status.res_last) begin
            out_valid_next = 1'b0;
            state_next     = S_IDLE;
          end else begin
            cmd.pop = 1'b1;
          end
        end
      end
      default: begin
        state_next     = S_IDLE;
        out_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A flush run always has a frame on show
  a_flush_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |-> out_valid)
    else $error("flush state without a valid result");

  // Pop only from a non-empty queue set
  a_pop_queued: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> status.any_queued)
    else $error("pop issued with all queues empty");

  // Leave a flush run only after its last frame is taken
  a_flush_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && !(out_ready && status.res_last)) |=> (state == S_FLUSH))
    else $error("flush run ended early");

  // At most one datapath command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.enq, cmd.outcome, cmd.pop, cmd.empty_flush}))
    else $error("conflicting datapath commands");
`endif

endmodule

// ===== bench/tb_priority_tx_queues_with_rate_adapt_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_tx_queues_with_rate_adapt_core: self-checking bench of the core
// Directed and random enqueue, flush and transmit-outcome transactions with
// random idling on both sides, checked field by field against a predictor of
// the class queues and the rate adaptation kept inside this bench.
// ----------------------------------------------------------------------------
module tb_priority_tx_queues_with_rate_adapt_core import ptq_pkg::*; ();

  localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
  localparam int CLASS_COUNT = DEF_CLASS_COUNT;
  localparam int LONG_HOLD   = 200;
  localparam logic [ACT_W-1:0] ACT_RESERVED = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [CLS_W-1:0] cls;
    logic [TAG_W-1:0] tag;
    logic             ok;
  } txq_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              dropped;
    logic [TOT_W-1:0]  drop_total;
    logic              has_frame;
    logic [TAG_W-1:0]  out_tag;
    logic [CLS_W-1:0]  out_class;
    logic [RATE_W-1:0] out_rate;
    logic              last;
    logic [RATE_W-1:0] current_rate;
    logic [TOT_W-1:0]  fallback_total;
  } txq_result_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [RATE_W-1:0] rate;
  } frame_entry_t;

  logic clk;
  logic rst;

  ptq_item_if   item_ch ();
  ptq_result_if result_ch ();
  ptq_cfg_if    cfg_ch ();

  priority_tx_queues_with_rate_adapt_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .CLASS_COUNT(CLASS_COUNT)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Stimulus and expectation stores
  txq_item_t   stim_items[$];
  txq_result_t expected_txq_results[$];

  // Predictor state
  frame_entry_t      frame_store [CLASS_COUNT][QUEUE_DEPTH];
  int                q_head [CLASS_COUNT];
  int                q_count [CLASS_COUNT];
  int                pred_rate;
  int                success_streak;
  int                failure_streak;
  logic [TOT_W-1:0]  drop_cnt;
  logic [TOT_W-1:0]  fallback_cnt;
  int                rate_ceiling;
  int                probe_count;

  // Bench control and statistics
  bit          idle_on;
  int          holds_asked;
  int          holds_granted;
  int          hold_left;
  int          send_gap;
  int          sink_gap;
  txq_item_t   send_next;
  txq_result_t got;
  txq_result_t want;
  int          error_count;
  int          items_accepted;
  int          results_checked;
  int          frames_flushed;
  int          drops_seen;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAIL priority_tx_queues_with_rate_adapt_core");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [TOT_W-1:0] seen,
                             input logic [TOT_W-1:0] exp);
    if (seen !== exp) begin
      report_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                results_checked, name, seen, exp));
    end
  endtask

  // Predict the results of one accepted transaction
  function automatic void txq_predict(input txq_item_t it);
    txq_result_t r;
    txq_result_t held;
    bit          have_held;
    int          c;
    int          slot;
    r = '0;
    held = '0;
    have_held = 1'b0;
    c = int'(it.cls);
    case (it.action)
      ACT_ENQUEUE: begin
        r.kind = KIND_STATUS;
        if (c >= CLASS_COUNT) begin
          r.dropped = 1'b1;
        end else if (q_count[c] >= QUEUE_DEPTH) begin
          r.dropped = 1'b1;
          drop_cnt = drop_cnt + 1'b1;
        end else begin
          slot = (q_head[c] + q_count[c]) % QUEUE_DEPTH;
          frame_store[c][slot].tag = it.tag;
          frame_store[c][slot].rate = RATE_W'(pred_rate);
          q_count[c]++;
        end
        r.drop_total = drop_cnt;
        expected_txq_results.push_back(r);
      end
      ACT_FLUSH: begin
        // Drain highest class first, FIFO within a class; hold back the
        // latest drained frame so the final one can be marked last
        for (int k = CLASS_COUNT - 1; k >= 0; k--) begin
          while (q_count[k] > 0) begin
            if (have_held) expected_txq_results.push_back(held);
            held = '0;
            held.kind = KIND_FRAME;
            held.has_frame = 1'b1;
            held.out_tag = frame_store[k][q_head[k]].tag;
            held.out_rate = frame_store[k][q_head[k]].rate;
            held.out_class = CLS_W'(k);
            q_head[k] = (q_head[k] + 1) % QUEUE_DEPTH;
            q_count[k]--;
            have_held = 1'b1;
          end
        end
        if (!have_held) held.kind = KIND_FRAME;
        held.last = 1'b1;
        expected_txq_results.push_back(held);
      end
      ACT_OUTCOME: begin
        if (it.ok) begin
          failure_streak = 0;
          if (success_streak < int'(RUN_MAX)) success_streak++;
          if (success_streak >= probe_count && pred_rate < rate_ceiling) begin
            pred_rate++;
            success_streak = 0;
          end
        end else begin
          success_streak = 0;
          if (failure_streak < int'(FAIL_LIMIT)) failure_streak++;
          if (failure_streak >= int'(FAIL_LIMIT) && pred_rate > 0) begin
            pred_rate--;
            failure_streak = 0;
            fallback_cnt = fallback_cnt + 1'b1;
          end
        end
        r.kind = KIND_RATE;
        r.current_rate = RATE_W'(pred_rate);
        r.fallback_total = fallback_cnt;
        expected_txq_results.push_back(r);
      end
      default: begin
        // reserved action: no result
      end
    endcase
  endfunction

  // Item driver: present the next pending transaction, with random gaps
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      item_ch.action <= ACT_ENQUEUE;
      item_ch.access_class <= '0;
      item_ch.frame_tag <= '0;
      item_ch.success <= 1'b0;
      send_gap <= 0;
    end else if (!item_ch.valid || item_ch.ready) begin
      if (send_gap > 0) begin
        item_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (idle_on && stim_items.size() != 0 && $urandom_range(0, 9) == 0) begin
        item_ch.valid <= 1'b0;
        send_gap <= $urandom_range(0, 5);
      end else if (stim_items.size() != 0) begin
        send_next = stim_items.pop_front();
        item_ch.valid <= 1'b1;
        item_ch.action <= send_next.action;
        item_ch.access_class <= send_next.cls;
        item_ch.frame_tag <= send_next.tag;
        item_ch.success <= send_next.ok;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: long hold-offs on request, otherwise random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_left <= 0;
      holds_granted <= 0;
      sink_gap <= 0;
    end else if (hold_left > 0) begin
      result_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_granted != holds_asked) begin
      result_ch.ready <= 1'b0;
      holds_granted <= holds_granted + 1;
      hold_left <= LONG_HOLD;
    end else if (sink_gap > 0) begin
      result_ch.ready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      result_ch.ready <= 1'b0;
      sink_gap <= $urandom_range(0, 5);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Monitor: check results first, then track register writes and new items
  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got.kind = result_ch.kind;
        got.dropped = result_ch.dropped;
        got.drop_total = result_ch.drop_total;
        got.has_frame = result_ch.has_frame;
        got.out_tag = result_ch.out_tag;
        got.out_class = result_ch.out_class;
        got.out_rate = result_ch.out_rate;
        got.last = result_ch.last;
        got.current_rate = result_ch.current_rate;
        got.fallback_total = result_ch.fallback_total;
        if (expected_txq_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected (kind %0d)", got.kind));
        end else begin
          want = expected_txq_results.pop_front();
          check_field("kind", TOT_W'(got.kind), TOT_W'(want.kind));
          check_field("dropped", TOT_W'(got.dropped), TOT_W'(want.dropped));
          check_field("drop_total", got.drop_total, want.drop_total);
          check_field("has_frame", TOT_W'(got.has_frame), TOT_W'(want.has_frame));
          check_field("out_tag", TOT_W'(got.out_tag), TOT_W'(want.out_tag));
          check_field("out_class", TOT_W'(got.out_class), TOT_W'(want.out_class));
          check_field("out_rate", TOT_W'(got.out_rate), TOT_W'(want.out_rate));
          check_field("last", TOT_W'(got.last), TOT_W'(want.last));
          check_field("current_rate", TOT_W'(got.current_rate), TOT_W'(want.current_rate));
          check_field("fallback_total", got.fallback_total, want.fallback_total);
          if (want.has_frame) frames_flushed++;
          if (want.dropped) drops_seen++;
        end
        results_checked++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_MAX_RATE: rate_ceiling = int'(cfg_ch.data[RATE_W-1:0]);
          CFG_PROBE:    probe_count = int'(cfg_ch.data);
          default: ;
        endcase
      end
      if (item_ch.valid && item_ch.ready) begin
        items_accepted++;
        txq_predict('{item_ch.action, item_ch.access_class, item_ch.frame_tag,
                      item_ch.success});
      end
    end
  end

  task automatic add_item(input logic [ACT_W-1:0] act, input int cls,
                          input int tag, input bit ok);
    stim_items.push_back('{act, CLS_W'(cls), TAG_W'(tag), ok});
  endtask

  // Wait until every transaction went in and every result came out
  task automatic wait_drained();
    do @(posedge clk);
    while (stim_items.size() != 0 || item_ch.valid || expected_txq_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random mix: mostly enqueues to a favored class and outcomes, few flushes
  task automatic add_random_items(input int count);
    int done;
    int pick;
    int hot;
    done = 0;
    hot = $urandom_range(0, CLASS_COUNT - 1);
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        add_item(ACT_ENQUEUE,
                 ($urandom_range(0, 2) != 0) ? hot : $urandom_range(0, CLASS_COUNT - 1),
                 $urandom_range(0, 65535), $urandom_range(0, 1));
        done++;
      end else if (pick < 88) begin
        add_item(ACT_OUTCOME, $urandom_range(0, 3), $urandom_range(0, 65535),
                 $urandom_range(0, 99) < 60);
        done++;
      end else if (pick < 95) begin
        add_item(ACT_FLUSH, $urandom_range(0, 3), $urandom_range(0, 65535),
                 $urandom_range(0, 1));
        hot = $urandom_range(0, CLASS_COUNT - 1);
        done++;
      end else begin
        add_item(ACT_RESERVED, $urandom_range(0, 3), $urandom_range(0, 65535),
                 $urandom_range(0, 1));
      end
    end
  endtask

  // Stimulus sequence
  initial begin
    int drain_cycles;
    int hot_class;
    rst = 1'b1;
    idle_on = 1'b0;
    holds_asked = 0;
    error_count = 0;
    items_accepted = 0;
    results_checked = 0;
    frames_flushed = 0;
    drops_seen = 0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_MAX_RATE;
    cfg_ch.data = '0;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      q_head[c] = 0;
      q_count[c] = 0;
    end
    pred_rate = 0;
    success_streak = 0;
    failure_streak = 0;
    drop_cnt = '0;
    fallback_cnt = '0;
    rate_ceiling = int'(RESET_MAX_RATE);
    probe_count = int'(RESET_PROBE);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    // Directed: empty flush, failures at rate zero, reserved action,
    // enqueues on every class with tag extremes, mixed flush
    add_item(ACT_FLUSH, 0, 0, 0);
    repeat (3) add_item(ACT_OUTCOME, 0, 0, 0);
    add_item(ACT_RESERVED, 3, 16'hFFFF, 1);
    add_item(ACT_ENQUEUE, 0, 16'h0000, 0);
    add_item(ACT_ENQUEUE, 3, 16'hFFFF, 1);
    add_item(ACT_ENQUEUE, 1, 16'h5A5A, 0);
    add_item(ACT_ENQUEUE, 2, 16'hA5A5, 1);
    add_item(ACT_ENQUEUE, 0, 16'h1234, 0);
    add_item(ACT_ENQUEUE, 3, 16'h0001, 0);
    add_item(ACT_OUTCOME, 0, 0, 1);
    add_item(ACT_FLUSH, 2, 16'hFFFF, 1);
    add_item(ACT_FLUSH, 0, 0, 0);
    add_item(ACT_OUTCOME, 0, 0, 0);
    wait_drained();

    // Zero probe count: every success climbs, up to the top rate
    write_reg(CFG_MAX_RATE, 8'h0F);
    write_reg(CFG_PROBE, 8'h00);
    for (int i = 0; i < 16; i++) begin
      add_item(ACT_OUTCOME, 0, 0, 1);
      if (i % 4 == 0) add_item(ACT_ENQUEUE, i / 4, $urandom_range(0, 65535), 0);
    end
    repeat (4) add_item(ACT_OUTCOME, 0, 0, 0);
    add_item(ACT_FLUSH, 0, 0, 0);
    wait_drained();

    // Rate above the ceiling: successes build a streak but never climb
    write_reg(CFG_MAX_RATE, 8'h02);
    write_reg(CFG_PROBE, 8'hFF);
    repeat (3) add_item(ACT_OUTCOME, 0, 0, 0);
    repeat (6) add_item(ACT_OUTCOME, 0, 0, 1);
    wait_drained();

    // Raise the ceiling and lower the probe count: the next success climbs
    write_reg(CFG_MAX_RATE, {4'($urandom_range(0, 15)), 4'hF});
    write_reg(CFG_PROBE, 8'h04);
    add_item(ACT_OUTCOME, 0, 0, 1);
    add_item(ACT_ENQUEUE, 1, $urandom_range(0, 65535), 1);
    add_item(ACT_FLUSH, 0, 0, 0);
    wait_drained();

    // Hold the sink off, then overflow one queue and run one full flush
    holds_asked++;
    hot_class = $urandom_range(0, CLASS_COUNT - 1);
    for (int k = 0; k <= QUEUE_DEPTH; k++) begin
      add_item(ACT_ENQUEUE, hot_class, $urandom_range(0, 65535), $urandom_range(0, 1));
    end
    for (int c = 0; c < CLASS_COUNT; c++) begin
      add_item(ACT_ENQUEUE, c, $urandom_range(0, 65535), $urandom_range(0, 1));
    end
    add_item(ACT_FLUSH, 0, 0, 0);
    add_item(ACT_FLUSH, 0, 0, 0);
    wait_drained();

    // Random traffic with idling
    write_reg(CFG_PROBE, 8'($urandom_range(1, 4)));
    write_reg(CFG_MAX_RATE, 8'($urandom_range(0, 255)));
    add_random_items(30);
    wait_drained();

    // Final stretch at full rate
    write_reg(CFG_PROBE, 8'($urandom_range(0, 3)));
    write_reg(CFG_MAX_RATE, 8'($urandom_range(0, 255)));
    idle_on = 1'b0;
    add_random_items(15);

    // Drain with a bound, then let trailing activity show up
    drain_cycles = 0;
    while ((stim_items.size() != 0 || item_ch.valid || expected_txq_results.size() != 0)
           && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    if (expected_txq_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_txq_results.size()));
    end

    $display("Covered %0d transactions in and %0d results out: %0d frames flushed,",
             items_accepted, results_checked, frames_flushed);
    $display("  %0d enqueue drops, %0d rate step-downs, final rate %0d.",
             drops_seen, fallback_cnt, pred_rate);
    if (error_count == 0) begin
      $display("PASS priority_tx_queues_with_rate_adapt_core");
    end else begin
      $display("FAIL priority_tx_queues_with_rate_adapt_core");
    end
    $finish;
  end

endmodule
